// File: sv/esc_pkg.sv
`timescale 1ns / 1ps

package esc_pkg;

  // Default length limit of an expression, in characters.
  localparam int MAX_LENGTH_DEF = 255;

  // Number of known function names.
  localparam int NUM_FUNCS = 9;

  // Character codes that the pair rules refer to.
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_X      = 8'h78;

  // Classification of one character.
  typedef struct packed {
    logic alpha;    // member of the expression alphabet
    logic letter;   // may appear in a function name
    logic fstart;   // first letter of some function name (c s t a l)
    logic op;       // binary operator
    logic digit;
    logic dot;
    logic lparen;
    logic rparen;
    logic var_x;
  } char_class_t;

  // Function names, packed one byte per letter with the first letter highest.
  localparam logic [31:0] FUNC_RUN [NUM_FUNCS] = '{
    32'h00636F73, 32'h0073696E, 32'h0074616E,
    32'h61636F73, 32'h6173696E, 32'h6174616E,
    32'h73717274, 32'h00006C6E, 32'h006C6F67
  };
  localparam logic [2:0] FUNC_LEN [NUM_FUNCS] = '{
    3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd2, 3'd3
  };

  // True when a letter run names one of the known functions.
  function automatic logic func_known(input logic [31:0] run, input logic [2:0] len);
    logic hit;
    hit = 1'b0;
    for (int f = 0; f < NUM_FUNCS; f++) begin
      if (run == FUNC_RUN[f] && len == FUNC_LEN[f]) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

// File: sv/esc_classify.sv
`timescale 1ns / 1ps

module esc_classify (
  input  logic [7:0]                ch,
  output esc_pkg::char_class_t      cls
);
  import esc_pkg::*;

  logic is_letter;
  logic is_op;
  logic is_dec;

  // Letters that can occur in function names.
  always_comb begin
    unique case (ch)
      8'h61, 8'h63, 8'h67, 8'h69, 8'h6C, 8'h6E,
      8'h6F, 8'h71, 8'h72, 8'h73, 8'h74: is_letter = 1'b1;
      default:                            is_letter = 1'b0;
    endcase
  end

  // Binary operators + - * / ^ %.
  always_comb begin
    unique case (ch)
      8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h5E, 8'h25: is_op = 1'b1;
      default:                                  is_op = 1'b0;
    endcase
  end

  assign is_dec = (ch >= 8'h30) && (ch <= 8'h39);

  // Collect the class bits.
  always_comb begin
    cls.letter = is_letter;
    cls.op     = is_op;
    cls.digit  = is_dec;
    cls.dot    = (ch == CH_DOT);
    cls.lparen = (ch == CH_LPAREN);
    cls.rparen = (ch == CH_RPAREN);
    cls.var_x  = (ch == CH_X);
    cls.fstart = (ch == 8'h63) || (ch == 8'h73) || (ch == 8'h74) ||
                 (ch == 8'h61) || (ch == 8'h6C);
    cls.alpha  = is_letter || is_op || is_dec || (ch == CH_DOT) ||
                 (ch == CH_LPAREN) || (ch == CH_RPAREN) || (ch == CH_X) ||
                 (ch == 8'h20) || (ch == 8'h7E);
  end

endmodule

// File: sv/esc_state.sv
`timescale 1ns / 1ps

module esc_state #(
  parameter int MAX_LENGTH = esc_pkg::MAX_LENGTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] ch,
  input  logic       last,
  output logic       verdict
);
  import esc_pkg::*;

  localparam int LenW = $clog2(MAX_LENGTH + 2);
  localparam logic [LenW-1:0] LenMax = LenW'(MAX_LENGTH);

  char_class_t     c;
  char_class_t     p_r, p_nxt;
  logic            have_p_r, have_p_nxt;
  logic [LenW-1:0] len_r, len_nxt;
  logic [9:0]      brace_r, brace_nxt;
  logic [1:0]      dot_r, dot_nxt;
  logic [31:0]     run_r, run_nxt;
  logic [2:0]      run_len_r, run_len_nxt;
  logic            err_r, err_nxt;
  logic            pair_err;
  logic            dot_err;
  logic            name_err;
  logic            final_err;
  logic            step_err;

  esc_classify u_classify (
    .ch  (ch),
    .cls (c)
  );

  // Pair rules between the previous and the current character.
  always_comb begin
    pair_err = 1'b0;
    if (have_p_r) begin
      if (c.lparen && (p_r.dot || p_r.rparen || p_r.digit || p_r.var_x)) pair_err = 1'b1;
      if (p_r.lparen && (c.dot || c.rparen || c.op)) pair_err = 1'b1;
      if (c.rparen && (p_r.dot || p_r.lparen || p_r.op)) pair_err = 1'b1;
      if (p_r.rparen && (c.dot || c.lparen || c.digit || c.var_x || c.fstart)) begin
        pair_err = 1'b1;
      end
      if (p_r.op && (c.op || c.rparen)) pair_err = 1'b1;
      if (c.digit && (p_r.rparen || p_r.var_x)) pair_err = 1'b1;
      if (p_r.digit && (c.lparen || c.var_x || c.fstart)) pair_err = 1'b1;
      if (c.var_x && (p_r.var_x || p_r.rparen || p_r.digit)) pair_err = 1'b1;
      if (p_r.var_x && (c.lparen || c.digit || c.fstart)) pair_err = 1'b1;
    end
  end

  // Counters, dot tracking and the letter run.
  always_comb begin
    len_nxt = (len_r <= LenMax) ? len_r + 1'b1 : len_r;

    brace_nxt = brace_r;
    if (c.lparen) begin
      brace_nxt = brace_r + 10'd1;
    end else if (c.rparen) begin
      brace_nxt = brace_r - 10'd1;
    end

    dot_err = 1'b0;
    dot_nxt = dot_r;
    if (c.dot) begin
      dot_nxt = (dot_r < 2'd2) ? dot_r + 2'd1 : dot_r;
      dot_err = (dot_r != 2'd0);
    end else if (!c.digit) begin
      dot_nxt = 2'd0;
    end

    name_err    = 1'b0;
    run_nxt     = run_r;
    run_len_nxt = run_len_r;
    if (c.letter) begin
      if (run_len_r < 3'd4) begin
        run_nxt     = {run_r[23:0], ch};
        run_len_nxt = run_len_r + 3'd1;
      end else begin
        run_len_nxt = 3'd5;
      end
    end else begin
      name_err    = (run_len_r != 3'd0) && (!c.lparen || !func_known(run_r, run_len_r));
      run_nxt     = '0;
      run_len_nxt = 3'd0;
    end

    step_err  = err_r || !c.alpha || pair_err || dot_err || name_err;
    final_err = (brace_nxt != 10'd0) || (run_len_nxt != 3'd0) || (len_nxt > LenMax);
    verdict   = !(step_err || final_err);
    err_nxt   = step_err;
    p_nxt      = c;
    have_p_nxt = 1'b1;
  end

  // State update; a verdict returns everything to the reset value.
  always_ff @(posedge clk) begin
    if (!rst_n || (step && last)) begin
      have_p_r  <= 1'b0;
      len_r     <= '0;
      brace_r   <= '0;
      dot_r     <= '0;
      run_r     <= '0;
      run_len_r <= '0;
      err_r     <= 1'b0;
      p_r       <= '0;
    end else if (step) begin
      have_p_r  <= have_p_nxt;
      len_r     <= len_nxt;
      brace_r   <= brace_nxt;
      dot_r     <= dot_nxt;
      run_r     <= run_nxt;
      run_len_r <= run_len_nxt;
      err_r     <= err_nxt;
      p_r       <= p_nxt;
    end
  end

  // The last character of an expression leaves a fresh state behind.
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    step && last |=> !have_p_r && len_r == '0 && !err_r && run_len_r == 3'd0)
    else $error("state not cleared after verdict");

  // A recorded error forces an invalid verdict.
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> !verdict)
    else $error("error lost before verdict");

  // The length counter never passes its saturation point.
  a_len_sat: assert property (@(posedge clk) disable iff (!rst_n)
    step && !last && len_r > LenMax |=> len_r == $past(len_r))
    else $error("length counter moved past saturation");

endmodule

// File: sv/expression_syntax_checker.sv
`timescale 1ns / 1ps

// Expression syntax checker.
// The input channel carries one character of expression text per beat in
// in_tdata, with in_tlast marking the final character. When that final beat
// has been processed, one result beat leaves on the output channel; bit 0 of
// out_tdata is 1 when the expression passed every check and 0 otherwise.
// Characters without in_tlast produce no output beat.
// out_tvalid rises when the result register loads. The last character waits
// in the input register while the state logic computes the verdict into the
// result register, and stays there until the result register is free.
// Throughput: one character per cycle when not stalled, set by the single
// state-update stage holding the previous character class and small counters.
// Reset (rst_n low, synchronous) empties both registers and returns the
// checker to the start of a new expression.
// When the receiver stalls, the result waits in the output register. Plain
// characters keep flowing; a second final character waits in the input
// register and in_tready drops until the pending result is taken.
module expression_syntax_checker #(
  parameter int MAX_LENGTH = esc_pkg::MAX_LENGTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] character
  input  logic       in_tlast,   // is_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] valid_res, [7:1] zero
);
  import esc_pkg::*;

  logic       s1_v_r;
  logic [7:0] s1_ch_r;
  logic       s1_last_r;
  logic       s1_adv;
  logic       out_free;
  logic       in_fire;
  logic       out_v_r;
  logic       res_r;
  logic       verdict;

  // Handshake between the input register and the result register.
  assign out_free  = !out_v_r || out_tready;
  assign s1_adv    = s1_v_r && (!s1_last_r || out_free);
  assign in_tready = !s1_v_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ch_r   <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  esc_state #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_adv),
    .ch      (s1_ch_r),
    .last    (s1_last_r),
    .verdict (verdict)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      res_r <= verdict;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'b0, res_r};

  // A processed final character always yields a result beat.
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_last_r |=> out_tvalid)
    else $error("final character produced no result");

  // Without a final character no result beat appears.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && !(s1_adv && s1_last_r) |=> !out_tvalid)
    else $error("result appeared without a final character");

  // The input side stalls only behind a blocked final character.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_v_r && s1_last_r && out_tvalid && !out_tready)
    else $error("input stalled without cause");

endmodule

// File: bench/tb_expression_syntax_checker.sv
`timescale 1ns / 1ps

module tb_expression_syntax_checker;
  import esc_pkg::*;

  localparam int MAX_LEN    = MAX_LENGTH_DEF;
  localparam int ITEM_GOAL  = 1900;
  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN_WAIT = 8;

  // One character beat on the input channel.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] character
  logic       in_tlast = 1'b0;    // is_last
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [0] valid_res, [7:1] zero

  char_beat_t pending_q[$];
  logic [7:0] expr_buf[$];
  bit         verdict_q[$];
  int         queued_count = 0;
  int         fail_count = 0;
  int         idle_cycles = 0;

  // Driver and monitor pacing.
  int         in_gap = 0;
  bit         in_steady = 1'b0;
  int         out_stall = 0;
  bit         out_steady = 1'b0;
  int         stall_draw;

  // Checker state as the predictor tracks it.
  logic [7:0] prev_ch;
  bit         have_prev;
  int         char_count;
  logic [9:0] paren_bal;
  int         dot_run;
  logic [31:0] word_run;
  int         word_len;
  bit         bad_expr;

  bit         got_verdict;
  bit         new_verdict;
  bit         exp_verdict;

  expression_syntax_checker u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Character classes used by the pair rules.
  function automatic bit is_dec(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bit is_op(input logic [7:0] c);
    case (c)
      "+", "-", "*", "/", "^", "%": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    case (c)
      "a", "c", "g", "i", "l", "n", "o", "q", "r", "s", "t": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit is_fstart(input logic [7:0] c);
    case (c)
      "c", "s", "t", "a", "l": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit in_alphabet(input logic [7:0] c);
    return is_dec(c) || is_op(c) || is_letter(c) || (c == " ") || (c == "~") ||
           (c == CH_DOT) || (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_X);
  endfunction

  function automatic bit name_is_func(input logic [31:0] run, input int len);
    case (len)
      2: return run == {16'd0, "ln"};
      3: return (run == {8'd0, "cos"}) || (run == {8'd0, "sin"}) ||
                (run == {8'd0, "tan"}) || (run == {8'd0, "log"});
      4: return (run == "acos") || (run == "asin") || (run == "atan") || (run == "sqrt");
      default: return 1'b0;
    endcase
  endfunction

  function automatic void clear_checker();
    prev_ch    = 8'h00;
    have_prev  = 1'b0;
    char_count = 0;
    paren_bal  = 10'd0;
    dot_run    = 0;
    word_run   = 32'd0;
    word_len   = 0;
    bad_expr   = 1'b0;
  endfunction

  // Advance the checker by one character; returns 1 when a verdict is due.
  function automatic bit judge_char(input logic [7:0] c, input bit last, output bit verdict);
    logic [7:0] p;
    p = prev_ch;
    verdict = 1'b0;
    if (!in_alphabet(c)) bad_expr = 1'b1;
    if (char_count <= MAX_LEN) char_count++;

    // Neighbor rules only apply once a previous character exists.
    if (have_prev) begin
      if (c == CH_LPAREN && (p == CH_DOT || p == CH_RPAREN || is_dec(p) || p == CH_X))
        bad_expr = 1'b1;
      if (p == CH_LPAREN && (c == CH_DOT || c == CH_RPAREN || is_op(c)))
        bad_expr = 1'b1;
      if (c == CH_RPAREN && (p == CH_DOT || p == CH_LPAREN || is_op(p)))
        bad_expr = 1'b1;
      if (p == CH_RPAREN && (c == CH_DOT || c == CH_LPAREN || is_dec(c) || c == CH_X ||
                             is_fstart(c)))
        bad_expr = 1'b1;
      if (is_op(p) && (is_op(c) || c == CH_RPAREN)) bad_expr = 1'b1;
      if (is_dec(c) && (p == CH_RPAREN || p == CH_X)) bad_expr = 1'b1;
      if (is_dec(p) && (c == CH_LPAREN || c == CH_X || is_fstart(c))) bad_expr = 1'b1;
      if (c == CH_X && (p == CH_X || p == CH_RPAREN || is_dec(p))) bad_expr = 1'b1;
      if (p == CH_X && (c == CH_LPAREN || is_dec(c) || is_fstart(c))) bad_expr = 1'b1;
    end

    // Parenthesis totals wrap at ten bits.
    if (c == CH_LPAREN) paren_bal = paren_bal + 10'd1;
    else if (c == CH_RPAREN) paren_bal = paren_bal - 10'd1;

    // A number may carry one dot.
    if (c == CH_DOT) begin
      if (dot_run < 2) dot_run++;
      if (dot_run > 1) bad_expr = 1'b1;
    end else if (!is_dec(c)) begin
      dot_run = 0;
    end

    // Letter runs must be a known function name followed directly by '('.
    if (is_letter(c)) begin
      if (word_len < 4) begin
        word_run = {word_run[23:0], c};
        word_len++;
      end else begin
        word_len = 5;
      end
    end else begin
      if (word_len > 0 && (c != CH_LPAREN || !name_is_func(word_run, word_len)))
        bad_expr = 1'b1;
      word_run = 32'd0;
      word_len = 0;
    end

    prev_ch   = c;
    have_prev = 1'b1;
    if (!last) return 1'b0;

    if (paren_bal != 10'd0) bad_expr = 1'b1;
    if (word_len > 0) bad_expr = 1'b1;
    if (char_count > MAX_LEN) bad_expr = 1'b1;
    verdict = !bad_expr;
    clear_checker();
    return 1'b1;
  endfunction

  // Expression text builders.
  function automatic void put(input logic [7:0] c);
    expr_buf.push_back(c);
  endfunction

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  function automatic void put_func_name(input int idx);
    case (idx)
      0: put_text("cos");
      1: put_text("sin");
      2: put_text("tan");
      3: put_text("acos");
      4: put_text("asin");
      5: put_text("atan");
      6: put_text("sqrt");
      7: put_text("ln");
      default: put_text("log");
    endcase
  endfunction

  function automatic void put_number();
    int n;
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) put(8'($urandom_range("0", "9")));
    if ($urandom_range(0, 3) == 0) begin
      put(CH_DOT);
      n = $urandom_range(0, 2);
      for (int i = 0; i < n; i++) put(8'($urandom_range("0", "9")));
    end
  endfunction

  function automatic void put_op();
    case ($urandom_range(0, 5))
      0: put("+");
      1: put("-");
      2: put("*");
      3: put("/");
      4: put("^");
      default: put("%");
    endcase
  endfunction

  // Well-formed expression with random operands, operators and nesting.
  function automatic void build_expr(input int max_terms);
    int open_cnt;
    int terms;
    bit done;
    open_cnt = 0;
    terms    = 0;
    done     = 1'b0;
    while (!done) begin
      if (terms < max_terms && $urandom_range(0, 5) == 0) begin
        if ($urandom_range(0, 1) == 1) put_func_name($urandom_range(0, 8));
        put(CH_LPAREN);
        open_cnt++;
      end else begin
        if ($urandom_range(0, 3) == 0) put(CH_X);
        else put_number();
        terms++;
        while (open_cnt > 0 && $urandom_range(0, 2) == 0) begin
          put(CH_RPAREN);
          open_cnt--;
        end
        if (terms >= max_terms) begin
          while (open_cnt > 0) begin
            put(CH_RPAREN);
            open_cnt--;
          end
          done = 1'b1;
        end else begin
          if ($urandom_range(0, 7) == 0) put(" ");
          put_op();
          if ($urandom_range(0, 7) == 0) put(" ");
        end
      end
    end
  endfunction

  // Break a well-formed expression in one place.
  function automatic void mutate_expr();
    string alpha;
    int    pos;
    alpha = " .0123456789()+~-*/^%acgilnoqrstx";
    pos   = $urandom_range(0, expr_buf.size() - 1);
    case ($urandom_range(0, 3))
      0: expr_buf[pos] = 8'($urandom_range(0, 255));
      1: expr_buf[pos] = alpha[$urandom_range(0, alpha.len() - 1)];
      2: expr_buf.insert(pos, expr_buf[pos]);
      default: if (expr_buf.size() > 1) expr_buf.delete(pos);
    endcase
  endfunction

  // Letter runs of random content, mostly closed by a call.
  function automatic void build_word();
    string letters;
    int    n;
    letters = "acgilnoqrst";
    if ($urandom_range(0, 1) == 1) begin
      put_func_name($urandom_range(0, 8));
    end else begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) put(letters[$urandom_range(0, letters.len() - 1)]);
    end
    if ($urandom_range(0, 4) != 0) begin
      put(CH_LPAREN);
      build_expr($urandom_range(1, 2));
      put(CH_RPAREN);
    end
  endfunction

  // Move the built text into the pending beats, last flag on its final character.
  function automatic void queue_expr();
    char_beat_t beat;
    for (int i = 0; i < expr_buf.size(); i++) begin
      beat.ch   = expr_buf[i];
      beat.last = (i == expr_buf.size() - 1);
      pending_q.push_back(beat);
      queued_count++;
    end
    expr_buf.delete();
  endfunction

  // Stimulus, then the end-of-run check.
  initial begin
    int kind;
    int n;

    clear_checker();

    // Directed: byte extremes, a function call, an open letter run, a bracketed sum,
    // reversed parentheses with balanced totals, and a double dot.
    put(8'h00);
    queue_expr();
    put(8'hFF);
    queue_expr();
    put_text("ln(x)");
    queue_expr();
    put_text("co");
    queue_expr();
    put_text("(1+x)");
    queue_expr();
    put_text(") (");
    queue_expr();
    put_text("1.5.2");
    queue_expr();

    // Length limit: exactly at it, one over it, and well past it.
    put("1");
    repeat (127) put_text("+1");
    queue_expr();
    put("1");
    repeat (127) put_text("+1");
    put(" ");
    queue_expr();
    build_expr(140);
    queue_expr();

    // Random expressions.
    while (queued_count < ITEM_GOAL) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        build_expr($urandom_range(1, 4));
      end else if (kind < 70) begin
        build_expr($urandom_range(1, 4));
        mutate_expr();
      end else if (kind < 85) begin
        build_word();
      end else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) put(8'($urandom_range(0, 255)));
      end
      queue_expr();
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_q.size() != 0 || in_tvalid || verdict_q.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Input driver: predicts each accepted beat and presents the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap    <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        got_verdict = judge_char(in_tdata, in_tlast, new_verdict);
        if (got_verdict) verdict_q.push_back(new_verdict);
      end
      if (in_tvalid && !in_tready) begin
        // Hold the beat until it is taken.
      end else if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap    <= in_gap - 1;
      end else if (pending_q.size() > 0) begin
        char_beat_t beat;
        beat = pending_q.pop_front();
        in_tdata  <= beat.ch;
        in_tlast  <= beat.last;
        in_tvalid <= 1'b1;
        if ($urandom_range(0, 39) == 0) in_steady = !in_steady;
        in_gap <= in_steady ? 0 : $urandom_range(0, 3);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor: compares each beat with the oldest verdict and paces out_tready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
      out_stall  <= 0;
    end else if (out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected result beat, out_tdata=%h", out_tdata);
        fail_count++;
      end else begin
        exp_verdict = verdict_q.pop_front();
        if (out_tdata[0] !== exp_verdict) begin
          $error("valid_res mismatch: expected %0b, actual %0b", exp_verdict, out_tdata[0]);
          fail_count++;
        end
        if (out_tdata[7:1] !== 7'd0) begin
          $error("out_tdata padding mismatch: expected 0, actual %h", out_tdata[7:1]);
          fail_count++;
        end
      end
      if ($urandom_range(0, 19) == 0) out_steady = !out_steady;
      // Stall length before the next result is taken.
      stall_draw = out_steady ? 0 : $urandom_range(0, 3);
      if (stall_draw == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        out_stall  <= stall_draw;
      end
    end else if (!out_tready) begin
      if (out_stall <= 1) out_tready <= 1'b1;
      out_stall <= out_stall - 1;
    end
  end

  // Watchdog: no beat on either side for too long ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// File: filelist.f
sv/esc_pkg.sv
sv/esc_classify.sv
sv/esc_state.sv
sv/expression_syntax_checker.sv
bench/tb_expression_syntax_checker.sv
